// ===== rtl/assert_macros.svh =====
// Assertion helpers shared by the RTL. All checks are sampled on clk and
// masked while arst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPLIES(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/dws_pkg.sv =====
package dws_pkg;

	localparam int DATA_W = 32;
	localparam int ACT_W  = 3;
	localparam int LEN_W  = 6;
	localparam int STAT_W = 2;

	localparam logic [ACT_W-1:0] ACT_PUSH_BACK  = 3'd0;
	localparam logic [ACT_W-1:0] ACT_PUSH_FRONT = 3'd1;
	localparam logic [ACT_W-1:0] ACT_POP_BACK   = 3'd2;
	localparam logic [ACT_W-1:0] ACT_POP_FRONT  = 3'd3;
	localparam logic [ACT_W-1:0] ACT_SORT       = 3'd4;

	localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
	localparam logic [STAT_W-1:0] STAT_FULL  = 2'd1;
	localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd2;

	// Per-cycle operation broadcast to every cell.
	localparam logic [2:0] CELL_HOLD       = 3'd0;
	localparam logic [2:0] CELL_PUSH_BACK  = 3'd1;
	localparam logic [2:0] CELL_SHIFT_UP   = 3'd2;
	localparam logic [2:0] CELL_SHIFT_DOWN = 3'd3;
	localparam logic [2:0] CELL_POP_BACK   = 3'd4;
	localparam logic [2:0] CELL_SORT       = 3'd5;

	typedef struct packed {
		logic [ACT_W-1:0]         action;
		logic signed [DATA_W-1:0] value;
	} in_item_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] popped;
		logic [LEN_W-1:0]         length;
		logic [STAT_W-1:0]        status;
	} out_item_t;

	typedef struct packed {
		logic [2:0]               op;
		logic                     phase;
		logic signed [DATA_W-1:0] value;
	} cell_ctl_t;

endpackage

// ===== rtl/dws_cell.sv =====
module dws_cell import dws_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  cell_ctl_t                ctl,
	input  logic                     pos_odd,
	input  logic signed [DATA_W-1:0] left_data,
	input  logic                     left_valid,
	input  logic signed [DATA_W-1:0] right_data,
	input  logic                     right_valid,
	output logic signed [DATA_W-1:0] data,
	output logic                     valid
);

	logic signed [DATA_W-1:0] data_q;
	logic                     valid_q;
	logic signed [DATA_W-1:0] data_nxt;
	logic                     valid_nxt;
	logic                     pair_left;

	assign pair_left = (pos_odd == ctl.phase);

	always_comb begin
		data_nxt  = data_q;
		valid_nxt = valid_q;
		case (ctl.op)
			CELL_PUSH_BACK: begin
				if (!valid_q && left_valid) begin
					data_nxt  = ctl.value;
					valid_nxt = 1'b1;
				end
			end
			CELL_SHIFT_UP: begin
				data_nxt  = left_data;
				valid_nxt = left_valid;
			end
			CELL_SHIFT_DOWN: begin
				data_nxt  = right_data;
				valid_nxt = right_valid;
			end
			CELL_POP_BACK: begin
				if (valid_q && !right_valid) begin
					valid_nxt = 1'b0;
				end
			end
			CELL_SORT: begin
				// One odd-even transposition step: both cells of a pair see the same compare.
				if (pair_left) begin
					if (valid_q && right_valid && (data_q > right_data)) begin
						data_nxt = right_data;
					end
				end else begin
					if (valid_q && left_valid && (left_data > data_q)) begin
						data_nxt = left_data;
					end
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= valid_nxt;
		end
	end

	always_ff @(posedge clk) begin
		data_q <= data_nxt;
	end

	assign data  = data_q;
	assign valid = valid_q;

endmodule

// ===== rtl/deque_with_insertion_sort.sv =====
// Channel  | Handshake            | Beat
// ---------+----------------------+-------------------------------------
// in       | in_valid / in_ready  | in_data: action, value
// out      | out_valid / out_ready| out_data: popped, length, status
//
// Push, pop and unused actions, and sorts of under two elements, put their result in the
// output register as the beat is taken. A sort of n elements (n >= 2) runs n odd-even
// steps through the cell row, during which no new beat is taken. A new beat is taken
// while the previous result is being taken. Reset empties the store; cell contents stay.
`include "assert_macros.svh"

module deque_with_insertion_sort import dws_pkg::*; #(
	parameter int CAPACITY = 32
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  in_item_t  in_data,
	output logic      out_valid,
	input  logic      out_ready,
	output out_item_t out_data
);

	localparam int CNT_W = $clog2(CAPACITY + 1);

	localparam logic S_IDLE = 1'b0;
	localparam logic S_SORT = 1'b1;

	logic                     state_q;
	logic [CNT_W-1:0]         count_q;
	logic [CNT_W-1:0]         pass_q;
	logic                     phase_q;
	logic                     out_valid_q;
	out_item_t                out_q;

	logic signed [DATA_W-1:0] cell_data [CAPACITY];
	logic [CAPACITY-1:0]      cell_valid;
	logic [CAPACITY-1:0]      cell_last;
	logic signed [DATA_W-1:0] back_val;
	cell_ctl_t                ctl;

	logic                     fire;
	logic                     full;
	logic                     empty;
	logic                     sort_start;
	logic                     sort_done;
	logic [CNT_W-1:0]         count_nxt;
	out_item_t                res;

	assign full     = (count_q == CNT_W'(CAPACITY));
	assign empty    = (count_q == '0);
	assign in_ready = (state_q == S_IDLE) && (!out_valid_q || out_ready);
	assign fire     = in_valid && in_ready;

	assign sort_start = fire && (in_data.action == ACT_SORT) && (count_q > CNT_W'(1));
	assign sort_done  = (state_q == S_SORT) && (pass_q == CNT_W'(1));

	assign cell_last = cell_valid & ~(cell_valid >> 1);

	always_comb begin
		back_val = '0;
		for (int k = 0; k < CAPACITY; k++) begin
			back_val = back_val | (cell_data[k] & {DATA_W{cell_last[k]}});
		end
	end

	always_comb begin
		ctl.op    = CELL_HOLD;
		ctl.phase = phase_q;
		ctl.value = in_data.value;
		count_nxt = count_q;
		res.popped = '0;
		res.status = STAT_OK;
		if (state_q == S_SORT) begin
			ctl.op = CELL_SORT;
		end else if (fire) begin
			case (in_data.action)
				ACT_PUSH_BACK: begin
					if (full) begin
						res.status = STAT_FULL;
					end else begin
						ctl.op    = CELL_PUSH_BACK;
						count_nxt = count_q + 1'b1;
					end
				end
				ACT_PUSH_FRONT: begin
					if (full) begin
						res.status = STAT_FULL;
					end else begin
						ctl.op    = CELL_SHIFT_UP;
						count_nxt = count_q + 1'b1;
					end
				end
				ACT_POP_BACK: begin
					if (empty) begin
						res.status = STAT_EMPTY;
					end else begin
						ctl.op     = CELL_POP_BACK;
						count_nxt  = count_q - 1'b1;
						res.popped = back_val;
					end
				end
				ACT_POP_FRONT: begin
					if (empty) begin
						res.status = STAT_EMPTY;
					end else begin
						ctl.op     = CELL_SHIFT_DOWN;
						count_nxt  = count_q - 1'b1;
						res.popped = cell_data[0];
					end
				end
				default: begin
				end
			endcase
		end
		res.length = LEN_W'(count_nxt);
	end

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic signed [DATA_W-1:0] l_data;
		logic                     l_valid;
		logic signed [DATA_W-1:0] r_data;
		logic                     r_valid;

		if (i == 0) begin : g_head
			// The head sees the pushed value on its left, but has no partner there when sorting.
			assign l_data  = in_data.value;
			assign l_valid = (ctl.op != CELL_SORT);
		end else begin : g_body
			assign l_data  = cell_data[i-1];
			assign l_valid = cell_valid[i-1];
		end

		if (i == CAPACITY - 1) begin : g_tail
			assign r_data  = '0;
			assign r_valid = 1'b0;
		end else begin : g_inner
			assign r_data  = cell_data[i+1];
			assign r_valid = cell_valid[i+1];
		end

		dws_cell u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.ctl         (ctl),
			.pos_odd     ((i % 2) == 1),
			.left_data   (l_data),
			.left_valid  (l_valid),
			.right_data  (r_data),
			.right_valid (r_valid),
			.data        (cell_data[i]),
			.valid       (cell_valid[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			pass_q      <= '0;
			phase_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			count_q <= count_nxt;
			// A new result replaces the one being taken in the same cycle.
			if ((fire && !sort_start) || sort_done) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (sort_start) begin
						state_q <= S_SORT;
						pass_q  <= count_q;
						phase_q <= 1'b0;
					end
				end
				S_SORT: begin
					pass_q  <= pass_q - 1'b1;
					phase_q <= ~phase_q;
					if (sort_done) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if ((fire && !sort_start) || sort_done) begin
			out_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	`ASSERT_IMPLIES(a_count_matches_cells, 1'b1, $countones(cell_valid) == count_q,
		"element count disagrees with occupied cells")
	`ASSERT_IMPLIES(a_cells_contiguous, 1'b1, ((cell_valid >> 1) & ~cell_valid) == '0,
		"occupied cells are not contiguous from the front")
	`ASSERT_IMPLIES(a_sort_holds_output, state_q == S_SORT, !out_valid_q && !in_ready,
		"output or intake active during a sort")
	`ASSERT_NEXT(a_push_grows, fire && (in_data.action == ACT_PUSH_BACK) && !full,
		count_q == $past(count_q) + 1'b1, "accepted push did not grow the store")

endmodule

// ===== verif/tb_deque_with_insertion_sort.sv =====
module tb_deque_with_insertion_sort;
	import dws_pkg::*;

	localparam int DEPTH = 32;
	localparam int RANDOM_ITEMS = 1630;
	localparam int CYCLE_LIMIT = 1_200_000;
	localparam logic [ACT_W-1:0] ACT_UNUSED_FIRST = 3'd5;

	typedef enum {MODE_FILL, MODE_DRAIN, MODE_MIXED} traffic_mode_e;

	// Shadow copy of the deque; predicts one result per accepted input beat.
	class deque_shadow;
		logic signed [DATA_W-1:0] cells [DEPTH];
		int unsigned              fill;
		out_item_t                expected_results [$];
		int                       mismatches;

		function new();
			fill = 0;
			mismatches = 0;
		endfunction

		function int pending();
			return expected_results.size();
		endfunction

		function void sort_cells();
			int i;
			int j;
			logic signed [DATA_W-1:0] t;
			for (i = 1; i < fill; i++) begin
				j = i;
				while (j > 0 && cells[j-1] > cells[j]) begin
					t = cells[j];
					cells[j] = cells[j-1];
					cells[j-1] = t;
					j--;
				end
			end
		endfunction

		function void note_beat(in_item_t it);
			out_item_t res;
			int k;
			res.popped = '0;
			res.status = STAT_OK;
			case (it.action)
				ACT_PUSH_BACK, ACT_PUSH_FRONT: begin
					if (fill >= DEPTH) begin
						res.status = STAT_FULL;
					end else if (it.action == ACT_PUSH_BACK) begin
						cells[fill] = it.value;
						fill++;
					end else begin
						for (k = fill; k > 0; k--)
							cells[k] = cells[k-1];
						cells[0] = it.value;
						fill++;
					end
				end
				ACT_POP_BACK: begin
					if (fill == 0) begin
						res.status = STAT_EMPTY;
					end else begin
						fill--;
						res.popped = cells[fill];
					end
				end
				ACT_POP_FRONT: begin
					if (fill == 0) begin
						res.status = STAT_EMPTY;
					end else begin
						res.popped = cells[0];
						for (k = 0; k + 1 < fill; k++)
							cells[k] = cells[k+1];
						fill--;
					end
				end
				ACT_SORT: begin
					sort_cells();
				end
				default: begin
				end
			endcase
			res.length = LEN_W'(fill);
			expected_results.push_back(res);
		endfunction

		function void check_beat(out_item_t got);
			out_item_t exp;
			if (expected_results.size() == 0) begin
				$error("result beat with nothing expected: popped %0d length %0d status %0d",
					got.popped, got.length, got.status);
				mismatches++;
				return;
			end
			exp = expected_results.pop_front();
			if (got.popped !== exp.popped) begin
				$error("popped: expected %0d, got %0d", exp.popped, got.popped);
				mismatches++;
			end
			if (got.length !== exp.length) begin
				$error("length: expected %0d, got %0d", exp.length, got.length);
				mismatches++;
			end
			if (got.status !== exp.status) begin
				$error("status: expected %0d, got %0d", exp.status, got.status);
				mismatches++;
			end
		endfunction
	endclass

	logic      clk;
	logic      arst_n;
	logic      in_valid;
	logic      in_ready;
	in_item_t  in_data;
	logic      out_valid;
	logic      out_ready;
	out_item_t out_data;

	deque_shadow shadow;
	int          cycles = 0;
	int          in_calm_left = 0;
	int          out_calm_left = 0;

	deque_with_insertion_sort #(.CAPACITY(DEPTH)) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready)
				shadow.note_beat(in_data);
			if (out_valid && out_ready)
				shadow.check_beat(out_data);
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("tb_deque_with_insertion_sort: errors");
			$finish;
		end
	end

	// Mostly short pauses, a few long ones, and now and then a stretch with none.
	function automatic int pause_len(ref int calm_left);
		int r;
		if (calm_left > 0) begin
			calm_left--;
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 2) begin
			calm_left = $urandom_range(20, 80);
			return 0;
		end
		if (r < 50)
			return 0;
		if (r < 88)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic signed [DATA_W-1:0] pick_value();
		case ($urandom_range(0, 9))
			0: return {1'b1, {(DATA_W-1){1'b0}}};
			1: return {1'b0, {(DATA_W-1){1'b1}}};
			2: return $urandom_range(0, 1) ? '0 : '1;
			3, 4: return DATA_W'($signed($urandom_range(0, 16)) - 8);
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [ACT_W-1:0] pick_action(traffic_mode_e mode);
		int r;
		int push_share;
		r = $urandom_range(0, 99);
		if (r < 3)
			return ACT_UNUSED_FIRST + ACT_W'($urandom_range(0, 2));
		if (r < 9)
			return ACT_SORT;
		push_share = (mode == MODE_FILL) ? 80 : (mode == MODE_DRAIN) ? 15 : 50;
		if ($urandom_range(0, 99) < push_share)
			return $urandom_range(0, 1) ? ACT_PUSH_BACK : ACT_PUSH_FRONT;
		return $urandom_range(0, 1) ? ACT_POP_BACK : ACT_POP_FRONT;
	endfunction

	function automatic in_item_t make_item(logic [ACT_W-1:0] action,
		logic signed [DATA_W-1:0] value);
		in_item_t it;
		it.action = action;
		it.value = value;
		return it;
	endfunction

	// Called just after a rising edge; returns right after the beat is taken.
	task automatic send_item(in_item_t it);
		int gap;
		gap = pause_len(in_calm_left);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= it;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
	endtask

	initial begin
		int stall;
		out_ready = 1'b0;
		wait (arst_n);
		@(posedge clk);
		forever begin
			out_ready <= 1'b1;
			repeat ($urandom_range(1, 12)) @(posedge clk);
			stall = pause_len(out_calm_left);
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
		end
	end

	initial begin
		in_item_t      directed [$];
		traffic_mode_e mode;
		int            sent;
		int            seg_left;
		shadow = new();
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Empty-store corner cases, one-element sort, extremes, duplicates, unused codes.
		directed.push_back(make_item(ACT_POP_BACK, 32'sd7));
		directed.push_back(make_item(ACT_POP_FRONT, -32'sd7));
		directed.push_back(make_item(ACT_SORT, '0));
		directed.push_back(make_item(ACT_PUSH_BACK, 32'sd5));
		directed.push_back(make_item(ACT_SORT, '1));
		directed.push_back(make_item(ACT_PUSH_FRONT, 32'sh7fff_ffff));
		directed.push_back(make_item(ACT_PUSH_BACK, 32'sh8000_0000));
		directed.push_back(make_item(ACT_PUSH_BACK, '0));
		directed.push_back(make_item(ACT_PUSH_FRONT, '1));
		directed.push_back(make_item(ACT_PUSH_BACK, '1));
		directed.push_back(make_item(ACT_SORT, 32'sh5555_aaaa));
		for (int k = 0; k < 3; k++)
			directed.push_back(make_item(ACT_UNUSED_FIRST + ACT_W'(k), '1));
		for (int k = 0; k < 7; k++)
			directed.push_back(make_item(k[0] ? ACT_POP_BACK : ACT_POP_FRONT, '1));
		foreach (directed[k])
			send_item(directed[k]);

		sent = 0;
		seg_left = 0;
		mode = MODE_MIXED;
		while (sent < RANDOM_ITEMS) begin
			if (seg_left == 0) begin
				case ($urandom_range(0, 2))
					0: mode = MODE_FILL;
					1: mode = MODE_DRAIN;
					default: mode = MODE_MIXED;
				endcase
				seg_left = (mode == MODE_MIXED) ? $urandom_range(10, 60)
					: $urandom_range(40, 120);
			end
			send_item(make_item(pick_action(mode), pick_value()));
			seg_left--;
			sent++;
		end
		in_valid <= 1'b0;

		while (shadow.pending() != 0)
			@(posedge clk);
		repeat (2 * DEPTH + 8) @(posedge clk);
		if (shadow.mismatches == 0)
			$display("tb_deque_with_insertion_sort: clean");
		else
			$display("tb_deque_with_insertion_sort: errors");
		$finish;
	end

endmodule

// ===== deque_with_insertion_sort.f =====
+incdir+rtl
rtl/dws_pkg.sv
rtl/dws_cell.sv
rtl/deque_with_insertion_sort.sv
verif/tb_deque_with_insertion_sort.sv
